// File: rtl/clpi_pkg.sv
// shared types, constants and lookup functions for the character lcd bus controller
package clpi_pkg;

    // command codes on the input channel
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_INIT   = 3'd1;
    localparam logic [2:0] CMD_INSTR  = 3'd2;
    localparam logic [2:0] CMD_DATA   = 3'd3;
    localparam logic [2:0] CMD_ADDR   = 3'd4;
    localparam logic [2:0] CMD_CGADDR = 3'd5;
    localparam logic [2:0] CMD_ROWCOL = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_SHORT_DELAY = 2'd0;
    localparam logic [1:0] CFG_LONG_DELAY  = 2'd1;
    localparam logic [1:0] CFG_PULSE       = 2'd2;

    localparam logic [15:0] SHORT_DELAY_RESET = 16'd20;
    localparam logic [23:0] LONG_DELAY_RESET  = 24'd50000;
    localparam logic [7:0]  PULSE_RESET       = 8'd1;

    localparam logic [7:0] ADDR_CMD_BIT  = 8'h80;
    localparam logic [7:0] CG_CMD_BIT    = 8'h40;
    localparam logic [7:0] CG_ADDR_MASK  = 8'h3F;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [15:0] short_delay_ticks;
        logic [23:0] long_delay_ticks;
        logic [7:0]  pulse_ticks;
    } cfg_t;

    // classified beat handed from front to back
    typedef struct packed {
        logic       real_cmd;
        logic       is_init;
        logic       is_data;
        logic [7:0] byte_value;
        logic [7:0] bus_in;
    } entry_t;

    function automatic logic [6:0] row_base(input logic [1:0] row);
        logic [6:0] base;
        unique case (row)
            2'd0: base = 7'h00;
            2'd1: base = 7'h40;
            2'd2: base = 7'h14;
            2'd3: base = 7'h54;
            default: base = 7'h00;
        endcase
        return base;
    endfunction

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0, 3'd1, 3'd2, 3'd3: b = 8'h38;
            3'd4: b = 8'h0C;
            3'd5: b = 8'h01;
            3'd6: b = 8'h06;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/clpi_front.sv
// front end: classifies a command beat and works out the byte to send
module clpi_front #(
    parameter int unsigned ROW_COUNT = 4,
    parameter int unsigned COL_COUNT = 20
) (
    input  logic [2:0]      s_command,
    input  logic [7:0]      s_byte_value,
    input  logic [2:0]      s_row,
    input  logic [4:0]      s_col,
    input  logic [7:0]      s_bus_in,
    output clpi_pkg::entry_t entry
);

    logic [7:0] cursor_sum;
    logic       cursor_ok;
    logic [7:0] send_byte;

    assign cursor_ok  = ({29'd0, s_row} < 32'(ROW_COUNT)) && ({27'd0, s_col} < 32'(COL_COUNT));
    assign cursor_sum = {1'b0, clpi_pkg::row_base(s_row[1:0])} + {3'b000, s_col};

    always_comb begin
        priority case (s_command)
            clpi_pkg::CMD_ADDR:
                send_byte = s_byte_value | clpi_pkg::ADDR_CMD_BIT;
            clpi_pkg::CMD_CGADDR:
                send_byte = (s_byte_value & clpi_pkg::CG_ADDR_MASK) | clpi_pkg::CG_CMD_BIT;
            clpi_pkg::CMD_ROWCOL:
                send_byte = (cursor_ok ? {1'b0, cursor_sum[6:0]} : 8'h00)
                            | clpi_pkg::ADDR_CMD_BIT;
            default:
                send_byte = s_byte_value;
        endcase
    end

    // code 7 behaves as a plain tick
    assign entry.real_cmd   = (s_command != clpi_pkg::CMD_TICK) && (s_command <= clpi_pkg::CMD_ROWCOL);
    assign entry.is_init    = (s_command == clpi_pkg::CMD_INIT);
    assign entry.is_data    = (s_command == clpi_pkg::CMD_DATA);
    assign entry.byte_value = send_byte;
    assign entry.bus_in     = s_bus_in;

endmodule

// File: rtl/clpi_queue.sv
// short queue of classified beats between front and back
module clpi_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  clpi_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output clpi_pkg::entry_t pop_entry,
    output logic             not_empty
);

    localparam int unsigned PTR_W = $clog2(clpi_pkg::QUEUE_DEPTH);

    clpi_pkg::entry_t  q_mem [clpi_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W:0]    count_reg;

    assign full      = (count_reg == (PTR_W+1)'(clpi_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = q_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) full |-> !push)
        else $error("queue written while full");
    assert property (@(posedge aclk) disable iff (!aresetn) !not_empty |-> !pop)
        else $error("queue read while empty");

endmodule

// File: rtl/clpi_back.sv
// back end: pin sequencer for init, busy polling and write pulses, with result register
module clpi_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  clpi_pkg::cfg_t   cfg,
    input  logic             q_not_empty,
    input  clpi_pkg::entry_t q_entry,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_e_line,
    output logic             m_rs_line,
    output logic             m_rw_line,
    output logic [7:0]       m_data_out,
    output logic             m_drive_data,
    output logic             m_ready_res,
    output logic             m_rejected
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT_WAIT,
        ST_INIT_PULSE,
        ST_INIT_GAP,
        ST_BUSY_PRE,
        ST_BUSY_HIGH,
        ST_WR_SETUP,
        ST_WR_PULSE
    } state_t;

    state_t      state_reg, state_next, target;
    logic [23:0] delay_reg, delay_next;
    logic [2:0]  repeat_reg, repeat_next;
    logic [7:0]  pbyte_reg, pbyte_next;
    logic        pdata_reg, pdata_next;
    logic        pin_e_reg, pin_e_next;
    logic        pin_rs_reg, pin_rs_next;
    logic        pin_rw_reg, pin_rw_next;
    logic [7:0]  pin_data_reg, pin_data_next;
    logic        pin_drive_reg, pin_drive_next;
    logic        rejected_reg, rejected_next;
    logic        m_valid_reg;
    logic        do_enter;
    logic [23:0] short_load, long_load, pulse_load;

    // a zero register counts as one tick
    assign short_load = (cfg.short_delay_ticks == '0) ? 24'd1 : {8'd0, cfg.short_delay_ticks};
    assign long_load  = (cfg.long_delay_ticks == '0) ? 24'd1 : cfg.long_delay_ticks;
    assign pulse_load = (cfg.pulse_ticks == '0) ? 24'd1 : {16'd0, cfg.pulse_ticks};

    // the pin registers are the result payload; a beat is stepped only when the slot frees
    assign q_pop = q_not_empty && (!m_valid_reg || m_ready);

    always_comb begin
        state_next     = state_reg;
        delay_next     = delay_reg;
        repeat_next    = repeat_reg;
        pbyte_next     = pbyte_reg;
        pdata_next     = pdata_reg;
        pin_e_next     = pin_e_reg;
        pin_rs_next    = pin_rs_reg;
        pin_rw_next    = pin_rw_reg;
        pin_data_next  = pin_data_reg;
        pin_drive_next = pin_drive_reg;
        rejected_next  = rejected_reg;
        do_enter       = 1'b0;
        target         = ST_IDLE;

        if (q_pop) begin
            rejected_next = 1'b0;
            if (state_reg == ST_IDLE && q_entry.real_cmd) begin
                repeat_next = '0;
                do_enter    = 1'b1;
                if (q_entry.is_init) begin
                    target = ST_INIT_WAIT;
                end else begin
                    pdata_next = q_entry.is_data;
                    pbyte_next = q_entry.byte_value;
                    target     = ST_BUSY_PRE;
                end
            end else begin
                rejected_next = q_entry.real_cmd;
                if (state_reg != ST_IDLE) begin
                    if (delay_reg > 24'd1) begin
                        delay_next = delay_reg - 24'd1;
                    end else begin
                        do_enter = 1'b1;
                        unique case (state_reg)
                            ST_INIT_WAIT: begin
                                if (repeat_reg < 3'd2) begin
                                    repeat_next = repeat_reg + 3'd1;
                                    target      = ST_INIT_WAIT;
                                end else begin
                                    repeat_next = '0;
                                    target      = ST_INIT_PULSE;
                                end
                            end
                            ST_INIT_PULSE: target = ST_INIT_GAP;
                            ST_INIT_GAP: begin
                                if (repeat_reg < 3'd6) begin
                                    repeat_next = repeat_reg + 3'd1;
                                    target      = ST_INIT_PULSE;
                                end else begin
                                    repeat_next = '0;
                                    target      = ST_IDLE;
                                end
                            end
                            ST_BUSY_PRE: target = ST_BUSY_HIGH;
                            // busy flag still set: poll again
                            ST_BUSY_HIGH: begin
                                if (q_entry.bus_in[7]) begin
                                    target = ST_BUSY_PRE;
                                end else if (pdata_reg) begin
                                    target = ST_WR_PULSE;
                                end else begin
                                    target = ST_WR_SETUP;
                                end
                            end
                            ST_WR_SETUP: target = ST_WR_PULSE;
                            ST_WR_PULSE: target = ST_IDLE;
                            ST_IDLE:     target = ST_IDLE;
                        endcase
                    end
                end
            end

            if (do_enter) begin
                state_next = target;
                unique case (target)
                    ST_INIT_WAIT: begin
                        pin_e_next     = 1'b0;
                        pin_rs_next    = 1'b0;
                        pin_rw_next    = 1'b0;
                        pin_data_next  = 8'h00;
                        pin_drive_next = 1'b1;
                        delay_next     = long_load;
                    end
                    ST_INIT_PULSE: begin
                        pin_e_next     = 1'b1;
                        pin_rs_next    = 1'b0;
                        pin_rw_next    = 1'b0;
                        pin_drive_next = 1'b1;
                        pin_data_next  = clpi_pkg::init_byte(repeat_next);
                        delay_next     = pulse_load;
                    end
                    ST_INIT_GAP: begin
                        pin_e_next = 1'b0;
                        delay_next = long_load;
                    end
                    ST_BUSY_PRE: begin
                        pin_e_next     = 1'b0;
                        pin_rs_next    = 1'b0;
                        pin_rw_next    = 1'b1;
                        pin_drive_next = 1'b0;
                        delay_next     = short_load;
                    end
                    ST_BUSY_HIGH: begin
                        pin_e_next = 1'b1;
                        delay_next = short_load;
                    end
                    ST_WR_SETUP: begin
                        pin_e_next     = 1'b0;
                        pin_rs_next    = 1'b0;
                        pin_rw_next    = 1'b0;
                        pin_drive_next = 1'b1;
                        pin_data_next  = pbyte_next;
                        delay_next     = short_load;
                    end
                    ST_WR_PULSE: begin
                        pin_e_next     = 1'b1;
                        pin_rs_next    = pdata_next;
                        pin_rw_next    = 1'b0;
                        pin_drive_next = 1'b1;
                        pin_data_next  = pbyte_next;
                        delay_next     = pulse_load;
                    end
                    ST_IDLE: begin
                        pin_e_next = 1'b0;
                        delay_next = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            delay_reg     <= '0;
            repeat_reg    <= '0;
            pbyte_reg     <= '0;
            pdata_reg     <= 1'b0;
            pin_e_reg     <= 1'b0;
            pin_rs_reg    <= 1'b0;
            pin_rw_reg    <= 1'b0;
            pin_data_reg  <= '0;
            pin_drive_reg <= 1'b0;
            rejected_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            delay_reg     <= delay_next;
            repeat_reg    <= repeat_next;
            pbyte_reg     <= pbyte_next;
            pdata_reg     <= pdata_next;
            pin_e_reg     <= pin_e_next;
            pin_rs_reg    <= pin_rs_next;
            pin_rw_reg    <= pin_rw_next;
            pin_data_reg  <= pin_data_next;
            pin_drive_reg <= pin_drive_next;
            rejected_reg  <= rejected_next;
            if (q_pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_e_line     = pin_e_reg;
    assign m_rs_line    = pin_rs_reg;
    assign m_rw_line    = pin_rw_reg;
    assign m_data_out   = pin_data_reg;
    assign m_drive_data = pin_drive_reg;
    assign m_ready_res  = (state_reg == ST_IDLE);
    assign m_rejected   = rejected_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_entry.real_cmd && state_reg == ST_IDLE) |=> !rejected_reg)
        else $error("command taken while idle was flagged as dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (delay_reg != '0))
        else $error("active phase with empty delay counter");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pin_e_reg)
        else $error("enable line high while idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(state_reg) && $stable(delay_reg))
        else $error("sequencer stepped while result stalled");

endmodule

// File: rtl/char_lcd_parallel_interface_top.sv
// top level of the character lcd bus controller: config registers, front, queue and back
// a beat accepted is written into the queue, then stepped into the pin and result registers
// one beat per clock unless stalled, each beat stepping the pin sequencer by exactly one tick
// the two-entry queue and the result register let either side stall without losing a beat
// reset: sequencer idle, pins low with lines released, queue empty, registers to defaults
// (short delay 20, long delay 50000, pulse 1)
module char_lcd_parallel_interface_top #(
    parameter int unsigned ROW_COUNT = 4,
    parameter int unsigned COL_COUNT = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [7:0]  s_byte_value,
    input  logic [2:0]  s_row,
    input  logic [4:0]  s_col,
    input  logic [7:0]  s_bus_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_e_line,
    output logic        m_rs_line,
    output logic        m_rw_line,
    output logic [7:0]  m_data_out,
    output logic        m_drive_data,
    output logic        m_ready_res,
    output logic        m_rejected,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    clpi_pkg::cfg_t   cfg_reg;
    clpi_pkg::entry_t front_entry;
    clpi_pkg::entry_t q_entry;
    logic             q_full;
    logic             q_not_empty;
    logic             q_pop;

    assign cfg_ready = 1'b1;

    // unknown register index is ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_delay_ticks <= clpi_pkg::SHORT_DELAY_RESET;
            cfg_reg.long_delay_ticks  <= clpi_pkg::LONG_DELAY_RESET;
            cfg_reg.pulse_ticks       <= clpi_pkg::PULSE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                clpi_pkg::CFG_SHORT_DELAY: cfg_reg.short_delay_ticks <= cfg_data[15:0];
                clpi_pkg::CFG_LONG_DELAY:  cfg_reg.long_delay_ticks  <= cfg_data;
                clpi_pkg::CFG_PULSE:       cfg_reg.pulse_ticks       <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign s_ready = !q_full;

    clpi_front #(
        .ROW_COUNT (ROW_COUNT),
        .COL_COUNT (COL_COUNT)
    ) u_front (
        .s_command    (s_command),
        .s_byte_value (s_byte_value),
        .s_row        (s_row),
        .s_col        (s_col),
        .s_bus_in     (s_bus_in),
        .entry        (front_entry)
    );

    clpi_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_valid && !q_full),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_entry),
        .not_empty  (q_not_empty)
    );

    clpi_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_not_empty  (q_not_empty),
        .q_entry      (q_entry),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_e_line     (m_e_line),
        .m_rs_line    (m_rs_line),
        .m_rw_line    (m_rw_line),
        .m_data_out   (m_data_out),
        .m_drive_data (m_drive_data),
        .m_ready_res  (m_ready_res),
        .m_rejected   (m_rejected)
    );

endmodule

// File: bench/tb_char_lcd_parallel_interface_top.sv
// self-checking bench for the character lcd bus controller, one result checked per tick beat
module tb_char_lcd_parallel_interface_top;
    import clpi_pkg::*;

    localparam int ROW_COUNT = 4;
    localparam int COL_COUNT = 20;
    localparam logic [2:0] CMD_UNKNOWN = 3'd7;
    localparam int RANDOM_ITEMS = 1200;
    localparam int DRAIN_CYCLES = 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_PRINTED = 30;
    // power-up bytes, first byte in the top lane
    localparam logic [63:0] INIT_BYTES = 64'h38383838_0C010600;
    localparam logic [31:0] ROW_BASES  = 32'h00_40_14_54;

    typedef enum logic [2:0] {
        SEQ_IDLE, SEQ_INIT_WAIT, SEQ_INIT_PULSE, SEQ_INIT_GAP,
        SEQ_POLL_LOW, SEQ_POLL_HIGH, SEQ_WR_SETUP, SEQ_WR_PULSE
    } seq_step_t;

    typedef struct packed {
        logic       e_line;
        logic       rs_line;
        logic       rw_line;
        logic [7:0] data_out;
        logic       drive_data;
        logic       ready_res;
        logic       rejected;
    } pin_levels_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_command = CMD_TICK;
    logic [7:0]  s_byte_value = 8'd0;
    logic [2:0]  s_row = 3'd0;
    logic [4:0]  s_col = 5'd0;
    logic [7:0]  s_bus_in = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_e_line;
    logic        m_rs_line;
    logic        m_rw_line;
    logic [7:0]  m_data_out;
    logic        m_drive_data;
    logic        m_ready_res;
    logic        m_rejected;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_SHORT_DELAY;
    logic [23:0] cfg_data = 24'd0;

    // sequencer model state
    seq_step_t   lcd_step = SEQ_IDLE;
    logic [23:0] lcd_ticks_left = 24'd0;
    logic [2:0]  init_index = 3'd0;
    logic [7:0]  queued_byte = 8'd0;
    logic        queued_is_data = 1'b0;
    logic        lcd_e = 1'b0;
    logic        lcd_rs = 1'b0;
    logic        lcd_rw = 1'b0;
    logic [7:0]  lcd_data = 8'd0;
    logic        lcd_drive = 1'b0;
    logic [15:0] short_ticks = SHORT_DELAY_RESET;
    logic [23:0] long_ticks = LONG_DELAY_RESET;
    logic [7:0]  pulse_len = PULSE_RESET;

    pin_levels_t lcd_pin_levels_q[$];

    int unsigned sender_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int          hold_off_left = 0;
    int          quiet_cycles = 0;
    int          error_count = 0;
    int          beats_sent = 0;
    int          results_checked = 0;
    int          cmds_taken = 0;
    int          cmds_dropped = 0;
    int          busy_repolls = 0;
    int          cfg_writes = 0;
    int          input_stall_cycles = 0;

    char_lcd_parallel_interface_top #(
        .ROW_COUNT(ROW_COUNT),
        .COL_COUNT(COL_COUNT)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_byte_value(s_byte_value),
        .s_row(s_row),
        .s_col(s_col),
        .s_bus_in(s_bus_in),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_e_line(m_e_line),
        .m_rs_line(m_rs_line),
        .m_rw_line(m_rw_line),
        .m_data_out(m_data_out),
        .m_drive_data(m_drive_data),
        .m_ready_res(m_ready_res),
        .m_rejected(m_rejected),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ---------------- sequencer model ----------------

    function automatic logic [23:0] at_least_one(input logic [23:0] v);
        return (v == 24'd0) ? 24'd1 : v;
    endfunction

    function automatic logic [6:0] cursor_address(input logic [2:0] row, input logic [4:0] col);
        logic [7:0] base;
        logic [7:0] sum;
        if (row >= ROW_COUNT || col >= COL_COUNT) return 7'd0;
        base = ROW_BASES[31 - 8 * row[1:0] -: 8];
        sum = base + {3'd0, col};
        return sum[6:0];
    endfunction

    function automatic void enter_step(input seq_step_t s);
        lcd_step = s;
        case (s)
            SEQ_INIT_WAIT: begin
                lcd_e = 1'b0; lcd_rs = 1'b0; lcd_rw = 1'b0; lcd_data = 8'd0; lcd_drive = 1'b1;
                lcd_ticks_left = at_least_one(long_ticks);
            end
            SEQ_INIT_PULSE: begin
                lcd_e = 1'b1; lcd_rs = 1'b0; lcd_rw = 1'b0; lcd_drive = 1'b1;
                lcd_data = INIT_BYTES[63 - 8 * init_index -: 8];
                lcd_ticks_left = at_least_one({16'd0, pulse_len});
            end
            SEQ_INIT_GAP: begin
                lcd_e = 1'b0;
                lcd_ticks_left = at_least_one(long_ticks);
            end
            SEQ_POLL_LOW: begin
                lcd_e = 1'b0; lcd_rs = 1'b0; lcd_rw = 1'b1; lcd_drive = 1'b0;
                lcd_ticks_left = at_least_one({8'd0, short_ticks});
            end
            SEQ_POLL_HIGH: begin
                lcd_e = 1'b1;
                lcd_ticks_left = at_least_one({8'd0, short_ticks});
            end
            SEQ_WR_SETUP: begin
                lcd_e = 1'b0; lcd_rs = 1'b0; lcd_rw = 1'b0; lcd_drive = 1'b1;
                lcd_data = queued_byte;
                lcd_ticks_left = at_least_one({8'd0, short_ticks});
            end
            SEQ_WR_PULSE: begin
                lcd_e = 1'b1; lcd_rs = queued_is_data; lcd_rw = 1'b0; lcd_drive = 1'b1;
                lcd_data = queued_byte;
                lcd_ticks_left = at_least_one({16'd0, pulse_len});
            end
            default: begin
                lcd_step = SEQ_IDLE;
                lcd_e = 1'b0;
                lcd_ticks_left = 24'd0;
            end
        endcase
    endfunction

    function automatic void advance_tick(input logic [7:0] bus);
        if (lcd_step == SEQ_IDLE) return;
        if (lcd_ticks_left > 24'd1) begin
            lcd_ticks_left = lcd_ticks_left - 24'd1;
            return;
        end
        case (lcd_step)
            SEQ_INIT_WAIT: begin
                if (init_index < 3'd2) begin
                    init_index = init_index + 3'd1;
                    enter_step(SEQ_INIT_WAIT);
                end else begin
                    init_index = 3'd0;
                    enter_step(SEQ_INIT_PULSE);
                end
            end
            SEQ_INIT_PULSE: enter_step(SEQ_INIT_GAP);
            SEQ_INIT_GAP: begin
                if (init_index < 3'd6) begin
                    init_index = init_index + 3'd1;
                    enter_step(SEQ_INIT_PULSE);
                end else begin
                    init_index = 3'd0;
                    enter_step(SEQ_IDLE);
                end
            end
            SEQ_POLL_LOW: enter_step(SEQ_POLL_HIGH);
            SEQ_POLL_HIGH: begin
                // busy flag still up: go round the poll again
                if (bus[7]) begin
                    busy_repolls++;
                    enter_step(SEQ_POLL_LOW);
                end else begin
                    enter_step(queued_is_data ? SEQ_WR_PULSE : SEQ_WR_SETUP);
                end
            end
            SEQ_WR_SETUP: enter_step(SEQ_WR_PULSE);
            default: enter_step(SEQ_IDLE);
        endcase
    endfunction

    function automatic pin_levels_t step_lcd_sequencer(input logic [2:0] cmd,
                                                       input logic [7:0] value,
                                                       input logic [2:0] row,
                                                       input logic [4:0] col,
                                                       input logic [7:0] bus);
        pin_levels_t levels;
        logic        real_cmd;
        logic        dropped;
        real_cmd = (cmd >= CMD_INIT) && (cmd <= CMD_ROWCOL);
        dropped = 1'b0;
        if (lcd_step == SEQ_IDLE && real_cmd) begin
            cmds_taken++;
            init_index = 3'd0;
            if (cmd == CMD_INIT) begin
                enter_step(SEQ_INIT_WAIT);
            end else begin
                queued_is_data = (cmd == CMD_DATA);
                case (cmd)
                    CMD_INSTR, CMD_DATA: queued_byte = value;
                    CMD_ADDR:            queued_byte = value | ADDR_CMD_BIT;
                    CMD_CGADDR:          queued_byte = (value & CG_ADDR_MASK) | CG_CMD_BIT;
                    default:             queued_byte = {1'b0, cursor_address(row, col)} | ADDR_CMD_BIT;
                endcase
                enter_step(SEQ_POLL_LOW);
            end
        end else begin
            dropped = real_cmd;
            if (real_cmd) cmds_dropped++;
            advance_tick(bus);
        end
        levels.e_line = lcd_e;
        levels.rs_line = lcd_rs;
        levels.rw_line = lcd_rw;
        levels.data_out = lcd_data;
        levels.drive_data = lcd_drive;
        levels.ready_res = (lcd_step == SEQ_IDLE);
        levels.rejected = dropped;
        return levels;
    endfunction

    // ---------------- channel drivers ----------------

    task automatic send_lcd_beat(input logic [2:0] cmd, input logic [7:0] value,
                                 input logic [2:0] row, input logic [4:0] col,
                                 input logic [7:0] bus);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_byte_value <= value;
        s_row <= row;
        s_col <= col;
        s_bus_in <= bus;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        lcd_pin_levels_q.push_back(step_lcd_sequencer(cmd, value, row, col, bus));
    endtask

    task automatic cfg_write(input logic [1:0] index, input logic [23:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_writes++;
        case (index)
            CFG_SHORT_DELAY: short_ticks = value[15:0];
            CFG_LONG_DELAY:  long_ticks = value;
            CFG_PULSE:       pulse_len = value[7:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_delays(input logic [23:0] short_v, input logic [23:0] long_v,
                              input logic [23:0] pulse_v);
        cfg_write(CFG_SHORT_DELAY, short_v);
        cfg_write(CFG_LONG_DELAY, long_v);
        cfg_write(CFG_PULSE, pulse_v);
    endtask

    function automatic logic [7:0] rand_bus(input int unsigned busy_pct);
        logic [7:0] bus;
        bus = 8'($urandom_range(255));
        bus[7] = ($urandom_range(99) < busy_pct);
        return bus;
    endfunction

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (lcd_pin_levels_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // tick until the sequencer is back to idle, then let every result out
    task automatic run_to_idle(input int unsigned busy_pct);
        while (lcd_step != SEQ_IDLE)
            send_lcd_beat(CMD_TICK, 8'($urandom_range(255)), 3'($urandom_range(7)),
                          5'($urandom_range(31)), rand_bus(busy_pct));
        drain_results();
    endtask

    task automatic write_and_settle(input logic [2:0] cmd, input logic [7:0] value,
                                    input logic [2:0] row, input logic [4:0] col);
        send_lcd_beat(cmd, value, row, col, rand_bus(0));
        run_to_idle(25);
    endtask

    task automatic random_beat();
        logic [2:0]  cmd;
        int unsigned roll;
        roll = $urandom_range(99);
        if (lcd_step == SEQ_IDLE) begin
            if (roll < 80) cmd = 3'($urandom_range(CMD_ROWCOL, CMD_INIT));
            else if (roll < 85) cmd = CMD_UNKNOWN;
            else cmd = CMD_TICK;
        end else begin
            if (roll < 8) cmd = 3'($urandom_range(CMD_ROWCOL, CMD_INIT));
            else if (roll < 12) cmd = CMD_UNKNOWN;
            else cmd = CMD_TICK;
        end
        send_lcd_beat(cmd, 8'($urandom_range(255)), 3'($urandom_range(7)),
                      5'($urandom_range(31)), rand_bus(30));
    endtask

    // ---------------- result side ----------------

    always @(negedge aclk) begin
        if (hold_off_left > 0) begin
            m_ready <= 1'b0;
            hold_off_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("mismatch: %s at result %0d, got %0h want %0h",
                     what, results_checked, got, want);
    endtask

    always @(posedge aclk) begin : check_pin_levels
        pin_levels_t want;
        if (aresetn && m_valid && m_ready) begin
            if (lcd_pin_levels_q.size() == 0) begin
                report_mismatch("result beat with nothing outstanding", 8'd0, 8'd0);
            end else begin
                want = lcd_pin_levels_q.pop_front();
                results_checked++;
                if (m_e_line !== want.e_line)
                    report_mismatch("e_line", 8'(m_e_line), 8'(want.e_line));
                if (m_rs_line !== want.rs_line)
                    report_mismatch("rs_line", 8'(m_rs_line), 8'(want.rs_line));
                if (m_rw_line !== want.rw_line)
                    report_mismatch("rw_line", 8'(m_rw_line), 8'(want.rw_line));
                if (m_data_out !== want.data_out)
                    report_mismatch("data_out", m_data_out, want.data_out);
                if (m_drive_data !== want.drive_data)
                    report_mismatch("drive_data", 8'(m_drive_data), 8'(want.drive_data));
                if (m_ready_res !== want.ready_res)
                    report_mismatch("ready_res", 8'(m_ready_res), 8'(want.ready_res));
                if (m_rejected !== want.rejected)
                    report_mismatch("rejected", 8'(m_rejected), 8'(want.rejected));
            end
        end
    end

    always @(posedge aclk) begin
        if (s_valid && !s_ready) input_stall_cycles++;
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_reset_defaults();
        send_lcd_beat(CMD_TICK, 8'hFF, 3'd7, 5'd31, 8'hFF);
        send_lcd_beat(CMD_UNKNOWN, 8'h00, 3'd0, 5'd0, 8'h00);
        write_and_settle(CMD_INSTR, 8'h01, 3'd0, 5'd0);
        send_lcd_beat(CMD_DATA, 8'hA5, 3'd0, 5'd0, rand_bus(0));
        run_to_idle(20);
    endtask

    task automatic test_init_sequence();
        set_delays(24'd2, 24'd3, 24'd2);
        send_lcd_beat(CMD_INIT, 8'h00, 3'd0, 5'd0, 8'h80);
        send_lcd_beat(CMD_DATA, 8'h41, 3'd0, 5'd0, 8'h80);
        send_lcd_beat(CMD_INIT, 8'h00, 3'd0, 5'd0, 8'h00);
        send_lcd_beat(CMD_UNKNOWN, 8'h00, 3'd0, 5'd0, 8'h00);
        // init never polls, so a set busy flag must not matter
        run_to_idle(50);
    endtask

    task automatic test_each_command();
        write_and_settle(CMD_INSTR, 8'h00, 3'd0, 5'd0);
        write_and_settle(CMD_INSTR, 8'hFF, 3'd0, 5'd0);
        write_and_settle(CMD_DATA, 8'h00, 3'd0, 5'd0);
        write_and_settle(CMD_DATA, 8'hFF, 3'd0, 5'd0);
        write_and_settle(CMD_ADDR, 8'h00, 3'd0, 5'd0);
        write_and_settle(CMD_ADDR, 8'hFF, 3'd0, 5'd0);
        write_and_settle(CMD_CGADDR, 8'h00, 3'd0, 5'd0);
        write_and_settle(CMD_CGADDR, 8'hFF, 3'd0, 5'd0);
        write_and_settle(CMD_ROWCOL, 8'h00, 3'd0, 5'd0);
        write_and_settle(CMD_ROWCOL, 8'h00, 3'd1, 5'd19);
        write_and_settle(CMD_ROWCOL, 8'h00, 3'd2, 5'd5);
        write_and_settle(CMD_ROWCOL, 8'h00, 3'd3, 5'd19);
        // cursor outside the 20x4 panel
        write_and_settle(CMD_ROWCOL, 8'h00, 3'd3, 5'd20);
        write_and_settle(CMD_ROWCOL, 8'h00, 3'd4, 5'd0);
        write_and_settle(CMD_ROWCOL, 8'hFF, 3'd7, 5'd31);
        // every command while the sequencer is busy gets dropped
        send_lcd_beat(CMD_INSTR, 8'h0C, 3'd0, 5'd0, 8'h00);
        for (int c = CMD_INIT; c <= CMD_ROWCOL; c++)
            send_lcd_beat(3'(c), 8'h55, 3'd1, 5'd1, 8'h00);
        send_lcd_beat(CMD_UNKNOWN, 8'hAA, 3'd2, 5'd2, 8'h00);
        run_to_idle(0);
    endtask

    task automatic test_stuck_busy();
        send_lcd_beat(CMD_DATA, 8'h5A, 3'd0, 5'd0, 8'h00);
        repeat (60) send_lcd_beat(CMD_TICK, 8'h00, 3'd0, 5'd0, 8'hFF);
        run_to_idle(0);
    endtask

    task automatic test_zero_registers();
        set_delays(24'd0, 24'd0, 24'd0);
        send_lcd_beat(CMD_INIT, 8'h00, 3'd0, 5'd0, 8'h00);
        run_to_idle(0);
        write_and_settle(CMD_INSTR, 8'h38, 3'd0, 5'd0);
        write_and_settle(CMD_DATA, 8'h7E, 3'd0, 5'd0);
    endtask

    task automatic test_extreme_registers();
        sender_idle_pct = 0;
        sink_stall_pct = 0;
        // short delay keeps only its low 16 bits, pulse only its low 8
        set_delays(24'hFF0001, 24'hFFFFFF, 24'd255);
        write_and_settle(CMD_INSTR, 8'h0C, 3'd0, 5'd0);
        cfg_write(CFG_PULSE, 24'h000101);
        write_and_settle(CMD_DATA, 8'hFF, 3'd0, 5'd0);
        write_and_settle(CMD_ROWCOL, 8'h00, 3'd3, 5'd7);
    endtask

    task automatic test_result_backpressure();
        set_delays(24'd3, 24'd4, 24'd2);
        sender_idle_pct = 0;
        sink_stall_pct = 0;
        // receiver sits out a long stretch while beats keep coming
        hold_off_left = HOLD_OFF_CYCLES;
        repeat (60) random_beat();
        run_to_idle(0);
    endtask

    task automatic test_random_traffic();
        int unsigned idle_modes[4][2];
        idle_modes = '{'{0, 0}, '{85, 0}, '{0, 85}, '{9, 9}};
        for (int p = 0; p < 4; p++) begin
            set_delays(24'($urandom_range(5, 1)), 24'($urandom_range(6, 1)),
                       24'($urandom_range(4, 1)));
            sender_idle_pct = idle_modes[p][0];
            sink_stall_pct = idle_modes[p][1];
            repeat (RANDOM_ITEMS / 4) random_beat();
            run_to_idle(0);
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        sender_idle_pct = 9;
        sink_stall_pct = 9;
        test_reset_defaults();
        test_init_sequence();
        test_each_command();
        test_stuck_busy();
        test_zero_registers();
        test_extreme_registers();
        test_result_backpressure();
        test_random_traffic();
        drain_results();
        $display("covered %0d tick beats: %0d commands taken, %0d dropped, %0d busy re-polls",
                 beats_sent, cmds_taken, cmds_dropped, busy_repolls);
        $display("checked %0d results over %0d register writes; input held back %0d cycles",
                 results_checked, cfg_writes, input_stall_cycles);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/clpi_pkg.sv
rtl/clpi_front.sv
rtl/clpi_queue.sv
rtl/clpi_back.sv
rtl/char_lcd_parallel_interface_top.sv
bench/tb_char_lcd_parallel_interface_top.sv
